@@ design/tun_pkg.sv @@
package tun_pkg;

    localparam int VERTEX_COUNT_DEF = 4096;
    localparam int COORD_BITS_DEF   = 32;

    localparam int IDX_W     = 12;
    localparam int FIELD_W   = 32;
    localparam int Q_FRAC    = 30;
    localparam int ROOT_BITS = Q_FRAC + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_Z = 2'd2;

    localparam logic ACT_VERTEX = 1'b0;
    localparam logic ACT_FACE   = 1'b1;

    // sideband that travels with a face through the math pipeline
    typedef struct packed {
        logic valid;
        logic degen;
    } t_flow;

    // request payload, first field in the lowest bits
    typedef struct packed {
        logic [IDX_W-1:0]   corner_c;
        logic [IDX_W-1:0]   corner_b;
        logic [IDX_W-1:0]   corner_a;
        logic [FIELD_W-1:0] coord_z;
        logic [FIELD_W-1:0] coord_y;
        logic [FIELD_W-1:0] coord_x;
        logic [IDX_W-1:0]   vertex_index;
    } t_in_data;

    typedef struct packed {
        logic [FIELD_W-1:0] normal_z;
        logic [FIELD_W-1:0] normal_y;
        logic [FIELD_W-1:0] normal_x;
    } t_out_data;

endpackage

@@ design/tun_vstore.sv @@
module tun_vstore #(
    parameter int VERTEX_COUNT = tun_pkg::VERTEX_COUNT_DEF,
    parameter int COORD_BITS   = tun_pkg::COORD_BITS_DEF,
    parameter int AW           = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rd_en,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic [3*COORD_BITS-1:0] i_wdata,
    input  logic [AW-1:0]           i_raddr_a,
    input  logic [AW-1:0]           i_raddr_b,
    input  logic [AW-1:0]           i_raddr_c,
    input  logic [2:0]              i_rok,
    output logic [3*COORD_BITS-1:0] o_rdata_a,
    output logic [3*COORD_BITS-1:0] o_rdata_b,
    output logic [3*COORD_BITS-1:0] o_rdata_c
);

    localparam int VW = 3 * COORD_BITS;

    // two copies: the first serves corners A and B, the second corner C
    logic [VW-1:0] r_mem0 [VERTEX_COUNT];
    logic [VW-1:0] r_mem1 [VERTEX_COUNT];
    logic [VW-1:0] r_rd_a, r_rd_b, r_rd_c;
    logic [2:0]    r_ok;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem0[i_waddr] <= i_wdata;
            r_mem1[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem0[i_raddr_a];
            r_rd_b <= r_mem0[i_raddr_b];
            r_rd_c <= r_mem1[i_raddr_c];
            r_ok   <= i_rok;
        end
    end

    // corners beyond the store read as the origin
    assign o_rdata_a = r_ok[0] ? r_rd_a : '0;
    assign o_rdata_b = r_ok[1] ? r_rd_b : '0;
    assign o_rdata_c = r_ok[2] ? r_rd_c : '0;

endmodule

@@ design/tun_cross.sv @@
module tun_cross #(
    parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_adv,
    input  tun_pkg::t_flow                        i_flow,
    input  logic [3*COORD_BITS-1:0]               i_vtx_a,
    input  logic [3*COORD_BITS-1:0]               i_vtx_b,
    input  logic [3*COORD_BITS-1:0]               i_vtx_c,
    output tun_pkg::t_flow                        o_flow,
    output logic [2:0]                            o_neg,
    output logic [4*(COORD_BITS+1)-1:0]           o_sq [3],
    output logic [4*(COORD_BITS+1)+1:0]           o_s
);

    localparam int CB  = COORD_BITS;
    localparam int D   = CB + 1;
    localparam int MW  = 2 * D;
    localparam int CW  = MW + 1;
    localparam int SQW = 2 * MW;
    localparam int SW  = SQW + 2;

    logic signed [D-1:0]  w_a [3];
    logic signed [D-1:0]  w_b [3];
    logic signed [D-1:0]  w_c [3];
    logic signed [D-1:0]  r_u [3];
    logic signed [D-1:0]  r_v [3];
    logic signed [MW-1:0] r_p [6];
    logic signed [CW-1:0] r_c [3];
    logic [MW-1:0]        r_mag [3];
    logic [MW-1:0]        r_hh [3];
    logic [MW-1:0]        r_hl [3];
    logic [MW-1:0]        r_ll [3];
    logic [SQW-1:0]       r_sq6 [3];
    logic [SQW-1:0]       r_sq7 [3];
    logic [SW-1:0]        r_s;
    logic [2:0]           r_neg4, r_neg5, r_neg6, r_neg7;
    logic [2:0]           w_neg;
    logic [MW-1:0]        w_mag [3];
    logic                 w_zero;
    tun_pkg::t_flow       r_f2, r_f3, r_f4, r_f5, r_f6, r_f7, r_f8;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a[i] = {i_vtx_a[i*CB+CB-1], i_vtx_a[i*CB +: CB]};
            w_b[i] = {i_vtx_b[i*CB+CB-1], i_vtx_b[i*CB +: CB]};
            w_c[i] = {i_vtx_c[i*CB+CB-1], i_vtx_c[i*CB +: CB]};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_neg[i] = r_c[i][CW-1];
            w_mag[i] = w_neg[i] ? MW'(-r_c[i]) : MW'(r_c[i]);
        end
        w_zero = (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
    end

    // r_f2..r_f8 run alongside r_u, r_p, r_c, r_mag, r_hh, r_sq6, r_s
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2 <= '0;
            r_f3 <= '0;
            r_f4 <= '0;
            r_f5 <= '0;
            r_f6 <= '0;
            r_f7 <= '0;
            r_f8 <= '0;
        end else if (i_adv) begin
            r_f2 <= i_flow;
            r_f3 <= r_f2;
            r_f4 <= r_f3;
            r_f5 <= '{valid: r_f4.valid, degen: w_zero};
            r_f6 <= r_f5;
            r_f7 <= r_f6;
            r_f8 <= r_f7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_u[i] <= w_b[i] - w_a[i];
                r_v[i] <= w_c[i] - w_a[i];
            end
            // cross product terms
            r_p[0] <= MW'(r_u[1]) * MW'(r_v[2]);
            r_p[1] <= MW'(r_u[2]) * MW'(r_v[1]);
            r_p[2] <= MW'(r_u[2]) * MW'(r_v[0]);
            r_p[3] <= MW'(r_u[0]) * MW'(r_v[2]);
            r_p[4] <= MW'(r_u[0]) * MW'(r_v[1]);
            r_p[5] <= MW'(r_u[1]) * MW'(r_v[0]);
            for (int i = 0; i < 3; i++) begin
                r_c[i] <= CW'(r_p[2*i]) - CW'(r_p[2*i+1]);
            end
            r_neg4 <= w_neg;
            r_mag  <= w_mag;
            // square of each magnitude from half-width limbs
            for (int i = 0; i < 3; i++) begin
                r_hh[i] <= MW'(r_mag[i][MW-1:D]) * MW'(r_mag[i][MW-1:D]);
                r_hl[i] <= MW'(r_mag[i][MW-1:D]) * MW'(r_mag[i][D-1:0]);
                r_ll[i] <= MW'(r_mag[i][D-1:0]) * MW'(r_mag[i][D-1:0]);
            end
            r_neg5 <= r_neg4;
            for (int i = 0; i < 3; i++) begin
                r_sq6[i] <= (SQW'(r_hh[i]) << MW) + (SQW'(r_hl[i]) << (D + 1))
                          + SQW'(r_ll[i]);
            end
            r_neg6 <= r_neg5;
            r_s    <= SW'(r_sq6[0]) + SW'(r_sq6[1]) + SW'(r_sq6[2]);
            r_sq7  <= r_sq6;
            r_neg7 <= r_neg6;
        end
    end

    assign o_flow = r_f8;
    assign o_neg  = r_neg7;
    assign o_sq   = r_sq7;
    assign o_s    = r_s;

endmodule

@@ design/tun_unit.sv @@
module tun_unit #(
    parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_adv,
    input  tun_pkg::t_flow                        i_flow,
    input  logic                                  i_neg,
    input  logic [4*(COORD_BITS+1)-1:0]           i_sq,
    input  logic [4*(COORD_BITS+1)+1:0]           i_s,
    output tun_pkg::t_flow                        o_flow,
    output logic [tun_pkg::FIELD_W-1:0]           o_value
);

    localparam int SQW = 4 * (COORD_BITS + 1);
    localparam int SW  = SQW + 2;
    localparam int K   = tun_pkg::ROOT_BITS;
    localparam int RW  = SW + 2 * K;
    localparam int PW  = SW + K;
    localparam int FW  = tun_pkg::FIELD_W;

    // m = floor(sqrt(sq * 2^60 / s)), one result bit per stage, MSB first.
    // Residual r = sq*2^60 - m^2*s and p = m*s are kept exactly.
    logic [RW-1:0]  w_r [K+1];
    logic [PW-1:0]  w_p [K+1];
    logic [K-1:0]   w_m [K+1];
    logic [SW-1:0]  w_s [K+1];
    logic           w_ng [K+1];
    tun_pkg::t_flow w_f [K+1];

    assign w_r[0]  = RW'(i_sq) << (2 * tun_pkg::Q_FRAC);
    assign w_p[0]  = '0;
    assign w_m[0]  = '0;
    assign w_s[0]  = i_s;
    assign w_ng[0] = i_neg;
    assign w_f[0]  = i_flow;

    for (genvar j = 0; j < K; j++) begin : g_stage
        localparam int KB = K - 1 - j;
        logic [RW-1:0]  w_t;
        logic           w_take;
        logic [RW-1:0]  r_r;
        logic [PW-1:0]  r_p;
        logic [K-1:0]   r_m;
        logic [SW-1:0]  r_sd;
        logic           r_ng;
        tun_pkg::t_flow r_f;

        // (m + 2^k)^2 s - m^2 s = p*2^(k+1) + s*2^(2k)
        assign w_t    = (RW'(w_p[j]) << (KB + 1)) + (RW'(w_s[j]) << (2 * KB));
        assign w_take = (w_t <= w_r[j]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_f <= '0;
            end else if (i_adv) begin
                r_f <= w_f[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_r  <= w_take ? (w_r[j] - w_t) : w_r[j];
                r_p  <= w_take ? (w_p[j] + (PW'(w_s[j]) << KB)) : w_p[j];
                r_m  <= w_take ? (w_m[j] | (K'(1) << KB)) : w_m[j];
                r_sd <= w_s[j];
                r_ng <= w_ng[j];
            end
        end

        assign w_r[j+1]  = r_r;
        assign w_p[j+1]  = r_p;
        assign w_m[j+1]  = r_m;
        assign w_s[j+1]  = r_sd;
        assign w_ng[j+1] = r_ng;
        assign w_f[j+1]  = r_f;
    end

    assign o_flow  = w_f[K];
    assign o_value = w_ng[K] ? (FW'(0) - FW'(w_m[K])) : FW'(w_m[K]);

endmodule

@@ design/triangle_unit_normal.sv @@
// Unit face normal of a triangle.
// Input stream: tuser is the action. A vertex request (action 0) writes the
// Q16.16 coordinates into the vertex slot and returns nothing. A face request
// (action 1) reads corners A, B, C and returns one Q1.30 unit normal of
// (B-A) x (C-A), truncated toward zero; an exactly zero cross product returns
// the default normal with tuser (degenerate) set.
// Config port: i_cfg_we writes i_cfg_data into default x/y/z (index 0..2);
// write only while no face is in flight.
// Throughput: one request per cycle while o_s_tready is high. A face result
// passes through the vertex memory read at the accepting edge, then 7
// cross product and norm stages, 31 root/divide stages, 1 output register.
// The 31 stages each resolve one bit of the result.
// A vertex written by one request is seen by any later face request.
// Reset clears the pipeline valids, the output valid and the default normal;
// vertex slots hold no reset value and must be written before use.
// When the receiver stalls, the result waits in the output register and the
// pipeline keeps running until the next result reaches the last stage; only
// then does o_s_tready drop.
module triangle_unit_normal #(
    parameter int VERTEX_COUNT = tun_pkg::VERTEX_COUNT_DEF,
    parameter int COORD_BITS   = tun_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // vertex_index, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
    input  logic [143:0]                      i_s_tdata,
    // action
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // normal_x, normal_y, normal_z
    output logic [95:0]                       o_m_tdata,
    // degenerate
    output logic                              o_m_tuser,
    input  logic                              i_cfg_we,
    input  logic [tun_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tun_pkg::FIELD_W-1:0]       i_cfg_data
);

    localparam int AW  = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int XW  = ((AW > tun_pkg::IDX_W) ? AW : tun_pkg::IDX_W) + 1;
    localparam int CB  = COORD_BITS;
    localparam int SQW = 4 * (CB + 1);
    localparam int SW  = SQW + 2;
    localparam int FW  = tun_pkg::FIELD_W;

    tun_pkg::t_in_data  w_in;
    tun_pkg::t_out_data r_out_data;
    logic               r_out_valid;
    logic               r_out_degen;
    logic [FW-1:0]      r_def_x, r_def_y, r_def_z;
    tun_pkg::t_flow     r_f1;
    tun_pkg::t_flow     w_cross_flow;
    tun_pkg::t_flow     w_last;
    tun_pkg::t_flow     w_flow_y, w_flow_z;
    logic               w_adv;
    logic               w_acc;
    logic               w_we;
    logic [XW-1:0]      w_wr_ext, w_a_ext, w_b_ext, w_c_ext;
    logic [2:0]         w_rok;
    logic [3*CB-1:0]    w_wdata;
    logic [3*CB-1:0]    w_vtx_a, w_vtx_b, w_vtx_c;
    logic [2:0]         w_neg;
    logic [SQW-1:0]     w_sq [3];
    logic [SW-1:0]      w_s;
    logic [FW-1:0]      w_nx, w_ny, w_nz;

    assign w_in = i_s_tdata;

    // the whole pipeline holds only when a result is waiting behind a stalled output
    assign w_adv      = !(r_out_valid && !i_m_tready && w_last.valid);
    assign o_s_tready = w_adv;
    assign w_acc      = i_s_tvalid && w_adv;

    assign w_wr_ext = XW'(w_in.vertex_index);
    assign w_a_ext  = XW'(w_in.corner_a);
    assign w_b_ext  = XW'(w_in.corner_b);
    assign w_c_ext  = XW'(w_in.corner_c);
    assign w_rok    = {w_c_ext < XW'(VERTEX_COUNT), w_b_ext < XW'(VERTEX_COUNT),
                       w_a_ext < XW'(VERTEX_COUNT)};
    assign w_we     = w_acc && (i_s_tuser == tun_pkg::ACT_VERTEX)
                      && (w_wr_ext < XW'(VERTEX_COUNT));
    assign w_wdata  = {w_in.coord_z[CB-1:0], w_in.coord_y[CB-1:0], w_in.coord_x[CB-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_x <= '0;
            r_def_y <= '0;
            r_def_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tun_pkg::CFG_DEFAULT_X: r_def_x <= i_cfg_data;
                tun_pkg::CFG_DEFAULT_Y: r_def_y <= i_cfg_data;
                tun_pkg::CFG_DEFAULT_Z: r_def_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1 <= '0;
        end else if (w_adv) begin
            r_f1 <= '{valid: w_acc && (i_s_tuser == tun_pkg::ACT_FACE), degen: 1'b0};
        end
    end

    tun_vstore #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .COORD_BITS   (COORD_BITS),
        .AW           (AW)
    ) u_vstore (
        .i_clk     (i_clk),
        .i_rd_en   (w_adv),
        .i_we      (w_we),
        .i_waddr   (w_wr_ext[AW-1:0]),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_a_ext[AW-1:0]),
        .i_raddr_b (w_b_ext[AW-1:0]),
        .i_raddr_c (w_c_ext[AW-1:0]),
        .i_rok     (w_rok),
        .o_rdata_a (w_vtx_a),
        .o_rdata_b (w_vtx_b),
        .o_rdata_c (w_vtx_c)
    );

    tun_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_flow  (r_f1),
        .i_vtx_a (w_vtx_a),
        .i_vtx_b (w_vtx_b),
        .i_vtx_c (w_vtx_c),
        .o_flow  (w_cross_flow),
        .o_neg   (w_neg),
        .o_sq    (w_sq),
        .o_s     (w_s)
    );

    tun_unit #(.COORD_BITS (COORD_BITS)) u_unit_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_adv (w_adv), .i_flow (w_cross_flow),
        .i_neg (w_neg[0]), .i_sq (w_sq[0]), .i_s (w_s),
        .o_flow (w_last), .o_value (w_nx)
    );

    tun_unit #(.COORD_BITS (COORD_BITS)) u_unit_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_adv (w_adv), .i_flow (w_cross_flow),
        .i_neg (w_neg[1]), .i_sq (w_sq[1]), .i_s (w_s),
        .o_flow (w_flow_y), .o_value (w_ny)
    );

    tun_unit #(.COORD_BITS (COORD_BITS)) u_unit_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_adv (w_adv), .i_flow (w_cross_flow),
        .i_neg (w_neg[2]), .i_sq (w_sq[2]), .i_s (w_s),
        .o_flow (w_flow_z), .o_value (w_nz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_last.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_last.valid) begin
            r_out_degen <= w_last.degen;
            if (w_last.degen) begin
                r_out_data <= '{normal_z: r_def_z, normal_y: r_def_y, normal_x: r_def_x};
            end else begin
                r_out_data <= '{normal_z: w_nz, normal_y: w_ny, normal_x: w_nx};
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_degen;

`ifndef SYNTH
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_tready)
        else $error("input stalled with empty output register");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_out_valid && !i_m_tready && w_last.valid && w_flow_y.valid
                         && w_flow_z.valid))
        else $error("input stalled without a blocked result");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |->
            ($signed(o_m_tdata[31:0]) <= 32'sd1073741824 &&
             $signed(o_m_tdata[31:0]) >= -32'sd1073741824))
        else $error("normal component out of unit range");
`endif

endmodule

@@ test/triangle_unit_normal_test.sv @@
module triangle_unit_normal_test;

    typedef struct {
        logic              action;
        tun_pkg::t_in_data data;
    } t_request;

    typedef struct {
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
        logic        degen;
    } t_normal;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [143:0] i_s_tdata;
    logic         i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [95:0]  o_m_tdata;
    logic         o_m_tuser;
    logic         i_cfg_we;
    logic [tun_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [tun_pkg::FIELD_W-1:0]   i_cfg_data;

    triangle_unit_normal dut (.*);

    // testbench copy of the vertex slots and default normal
    logic signed [31:0] vx_mem [4096];
    logic signed [31:0] vy_mem [4096];
    logic signed [31:0] vz_mem [4096];
    logic [31:0]        dflt [3];
    bit                 slot_written [4096];
    int                 written_slots [$];

    t_request pending_q [$];
    t_normal  normal_q [$];
    t_request cur_req;
    int       send_idle;
    int       recv_stall;
    int       hold_left;
    bit       hold_start;
    int       errors;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        #(20 * 3000000);
        $display("CHECKS FAILED");
        $finish;
    end

    // Q1.30 c * 2^30 / sqrt(s), truncated toward zero
    function automatic logic [31:0] unit_comp(logic signed [66:0] c, logic [255:0] s);
        logic signed [255:0] cw;
        logic [255:0] mag, t, lo, hi, mid;
        cw = c;
        mag = (cw < 0) ? -cw : cw;
        t = (mag * mag) << 60;
        lo = 0;
        hi = 256'd1 << 30;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (mid * mid * s <= t) lo = mid;
            else hi = mid - 1;
        end
        return (cw < 0) ? -lo[31:0] : lo[31:0];
    endfunction

    function automatic t_normal face_normal(tun_pkg::t_in_data d);
        logic signed [66:0] ux, uy, uz, wx, wy, wz, cx, cy, cz;
        logic signed [255:0] ex, ey, ez;
        logic [255:0] s;
        t_normal r;
        ux = vx_mem[d.corner_b] - vx_mem[d.corner_a];
        uy = vy_mem[d.corner_b] - vy_mem[d.corner_a];
        uz = vz_mem[d.corner_b] - vz_mem[d.corner_a];
        wx = vx_mem[d.corner_c] - vx_mem[d.corner_a];
        wy = vy_mem[d.corner_c] - vy_mem[d.corner_a];
        wz = vz_mem[d.corner_c] - vz_mem[d.corner_a];
        cx = uy * wz - uz * wy;
        cy = uz * wx - ux * wz;
        cz = ux * wy - uy * wx;
        if (cx == 0 && cy == 0 && cz == 0) begin
            r.nx = dflt[tun_pkg::CFG_DEFAULT_X];
            r.ny = dflt[tun_pkg::CFG_DEFAULT_Y];
            r.nz = dflt[tun_pkg::CFG_DEFAULT_Z];
            r.degen = 1'b1;
            return r;
        end
        ex = cx;
        ey = cy;
        ez = cz;
        s = ex * ex + ey * ey + ez * ez;
        r.nx = unit_comp(cx, s);
        r.ny = unit_comp(cy, s);
        r.nz = unit_comp(cz, s);
        r.degen = 1'b0;
        return r;
    endfunction

    // driver; prediction happens at acceptance, in request order
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                if (cur_req.action == tun_pkg::ACT_VERTEX) begin
                    vx_mem[cur_req.data.vertex_index] = cur_req.data.coord_x;
                    vy_mem[cur_req.data.vertex_index] = cur_req.data.coord_y;
                    vz_mem[cur_req.data.vertex_index] = cur_req.data.coord_z;
                end else begin
                    normal_q.push_back(face_normal(cur_req.data));
                end
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    cur_req = pending_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= cur_req.data;
                    i_s_tuser <= cur_req.action;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            hold_left = 0;
        end else begin
            if (hold_start) begin
                hold_start = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    always @(posedge i_clk) begin
        tun_pkg::t_out_data got;
        t_normal            want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (normal_q.size() == 0) begin
                $display("%0t: unexpected result %h deg %b", $time, o_m_tdata, o_m_tuser);
                errors++;
            end else begin
                want = normal_q.pop_front();
                if (got.normal_x !== want.nx || got.normal_y !== want.ny ||
                    got.normal_z !== want.nz || o_m_tuser !== want.degen) begin
                    $display("%0t: mismatch expected %h %h %h deg %b, actual %h %h %h deg %b",
                             $time, want.nx, want.ny, want.nz, want.degen,
                             got.normal_x, got.normal_y, got.normal_z, o_m_tuser);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
            3: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return 32'd0;
        endcase
    endfunction

    task automatic push_vertex(int slot, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_request r;
        r.action = tun_pkg::ACT_VERTEX;
        r.data = '0;
        r.data.vertex_index = tun_pkg::IDX_W'(slot);
        r.data.coord_x = x;
        r.data.coord_y = y;
        r.data.coord_z = z;
        r.data.corner_a = tun_pkg::IDX_W'($urandom());
        r.data.corner_b = tun_pkg::IDX_W'($urandom());
        r.data.corner_c = tun_pkg::IDX_W'($urandom());
        pending_q.push_back(r);
        if (!slot_written[slot]) begin
            slot_written[slot] = 1'b1;
            written_slots.push_back(slot);
        end
    endtask

    task automatic push_face(int a, int b, int c);
        t_request r;
        r.action = tun_pkg::ACT_FACE;
        r.data.vertex_index = tun_pkg::IDX_W'($urandom());
        r.data.coord_x = $urandom();
        r.data.coord_y = $urandom();
        r.data.coord_z = $urandom();
        r.data.corner_a = tun_pkg::IDX_W'(a);
        r.data.corner_b = tun_pkg::IDX_W'(b);
        r.data.corner_c = tun_pkg::IDX_W'(c);
        pending_q.push_back(r);
    endtask

    function automatic int any_slot();
        return written_slots[$urandom_range(0, written_slots.size() - 1)];
    endfunction

    task automatic cfg_write(logic [tun_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        dflt[idx] = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // block idle: all requests taken, all results back, pipeline drained
    task automatic drain();
        while (pending_q.size() > 0 || i_s_tvalid || normal_q.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic random_batch(int count);
        int a, b, c;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 35) begin
                push_vertex($urandom_range(0, 4095), rand_coord(), rand_coord(), rand_coord());
            end else begin
                a = any_slot();
                b = any_slot();
                c = any_slot();
                // repeated corners give degenerate faces now and then
                case ($urandom_range(9))
                    0: b = a;
                    1: c = b;
                    2: c = a;
                    default: ;
                endcase
                push_face(a, b, c);
            end
        end
    endtask

    initial begin
        errors = 0;
        hold_start = 1'b0;
        send_idle = 0;
        recv_stall = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_m_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        foreach (dflt[i]) dflt[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset defaults, extremes, axis normals, degenerate faces
        push_vertex(0, 32'd0, 32'd0, 32'd0);
        push_vertex(4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_vertex(2048, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_vertex(1, 32'h0001_0000, 32'd0, 32'd0);
        push_vertex(2, 32'd0, 32'h0001_0000, 32'd0);
        push_vertex(3, 32'd0, 32'd0, 32'h0001_0000);
        push_vertex(2047, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        push_vertex(3000, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF);
        push_vertex(5, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
        push_face(0, 1, 2);
        push_face(0, 2, 1);
        push_face(0, 2, 3);
        push_face(0, 3, 1);
        push_face(1, 2, 3);
        push_face(0, 0, 0);
        push_face(0, 4095, 2048);
        push_face(4095, 2047, 3000);
        push_face(2048, 3000, 2047);
        push_face(2048, 4095, 2047);
        push_face(0, 5, 4095);
        push_face(3000, 3000, 1);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin cfg_write(tun_pkg::CFG_DEFAULT_X, 32'h4000_0000);
                   cfg_write(tun_pkg::CFG_DEFAULT_Y, 32'hC000_0000);
                   cfg_write(tun_pkg::CFG_DEFAULT_Z, 32'd0); end
                1: begin cfg_write(tun_pkg::CFG_DEFAULT_X, 32'hC000_0000);
                   cfg_write(tun_pkg::CFG_DEFAULT_Y, 32'h4000_0000);
                   cfg_write(tun_pkg::CFG_DEFAULT_Z, 32'h4000_0000); end
                2: begin cfg_write(tun_pkg::CFG_DEFAULT_X, 32'h8000_0000);
                   cfg_write(tun_pkg::CFG_DEFAULT_Y, 32'h7FFF_FFFF);
                   cfg_write(tun_pkg::CFG_DEFAULT_Z, 32'hFFFF_FFFF); end
                default: begin cfg_write(tun_pkg::CFG_DEFAULT_X, $urandom());
                   cfg_write(tun_pkg::CFG_DEFAULT_Y, $urandom_range(0, 32'h4000_0000));
                   cfg_write(tun_pkg::CFG_DEFAULT_Z, -$urandom_range(0, 32'h4000_0000)); end
            endcase
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 48; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 48; end
                3: begin send_idle = 32; recv_stall = 32; end
                4: begin send_idle = 0;  recv_stall = 0;  hold_start = 1'b1; end
                default: begin send_idle = $urandom_range(0, 40);
                   recv_stall = $urandom_range(0, 40); end
            endcase
            random_batch(72);
            drain();
        end

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
